FILE: rtl/frequency_bucket_mode_tracker_unit_defines.svh
// Assertion macros for the frequency bucket mode tracker.
// Used by the top-level RTL file, which carries the checks; expects clk and rst_n in scope.
`ifndef FREQUENCY_BUCKET_MODE_TRACKER_UNIT_DEFINES_SVH
`define FREQUENCY_BUCKET_MODE_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FBMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FBMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fbmt_pkg.sv
// Shared types and constants of the frequency bucket mode tracker.
// No dependencies.
`default_nettype none

package fbmt_pkg;

  localparam int unsigned VALUES_DEF    = 1023;
  localparam int unsigned MAX_COUNT_DEF = 1023;

  // Fixed widths of the beat fields
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned COUNT_W = 10;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mode_value;
    logic [COUNT_W-1:0] max_count;
    logic               error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UNLINK,
    ST_LINK,
    ST_FIX
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/frequency_bucket_mode_tracker_unit.sv
// Top level of the frequency bucket mode tracker: sequencer, link logic, state memories.
// Depends on fbmt_pkg, fbmt_ram and frequency_bucket_mode_tracker_unit_defines.svh.
`default_nettype none
`include "frequency_bucket_mode_tracker_unit_defines.svh"

// Usage
//   Input: drive in_data and raise start; the beat is taken on the edge where start is
//   high and busy is low. in_data.opcode adds or removes one occurrence of in_data.value.
//   Output: exactly one result per beat, on out_data for a single cycle with out_valid
//   high. The receiver has no way to stall; it must take the result in that cycle.
//   Sequence: a normal item steps through the UNLINK, LINK and FIX states with busy high;
//   its result is registered out of FIX, and the next item can be taken as the result shows.
//   An ignored item (bad value, add at the count limit, remove at zero) reports straight
//   from UNLINK and skips LINK and FIX.
//   The sequence comes from the back-link memory: its single write port takes three dependent
//   writes per item (unlink neighbor, old head, the value itself), after a registered read.
//   Reset: synchronous, active low. After reset the block sweeps all memories, one entry
//   per cycle over max(VALUES, MAX_COUNT) + 1 indices (1024 at the defaults), with busy high.
//   Nothing is held: results report mode_value and max_count as 0 until a value is added.
module frequency_bucket_mode_tracker_unit #(
  parameter int unsigned VALUES    = fbmt_pkg::VALUES_DEF,
  parameter int unsigned MAX_COUNT = fbmt_pkg::MAX_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire fbmt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output fbmt_pkg::out_item_t      out_data
);

  localparam int unsigned VW   = $clog2(VALUES + 1);
  localparam int unsigned CW   = $clog2(MAX_COUNT + 1);
  localparam int unsigned IW   = (VW > CW) ? VW : CW;
  localparam int unsigned BW   = IW + 1;
  localparam int unsigned NCLR = ((VALUES > MAX_COUNT) ? VALUES : MAX_COUNT) + 1;
  localparam int unsigned CLW  = $clog2(NCLR);
  localparam int unsigned OVW  = fbmt_pkg::VALUE_W;
  localparam int unsigned OCW  = fbmt_pkg::COUNT_W;

  fbmt_pkg::state_t    state_r, state_nxt;
  logic [CLW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [CLW:0]        clr_inc;
  fbmt_pkg::op_t       op_r, op_nxt;
  logic [VW-1:0]       v_r, v_nxt;
  logic                vld_r, vld_nxt;
  logic [CW-1:0]       newc_r, newc_nxt;
  logic [CW-1:0]       highest_r, highest_nxt;
  logic [VW-1:0]       mode_r, mode_nxt;
  logic                out_valid_r, out_valid_nxt;
  fbmt_pkg::out_item_t out_data_r, out_data_nxt;

  // memory ports
  logic          cnt_we, hd_we, nx_we, bk_we;
  logic [VW-1:0] cnt_waddr, cnt_raddr, nx_waddr, nx_raddr, bk_waddr, bk_raddr;
  logic [CW-1:0] hd_waddr, hd_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic [VW-1:0] hd_wdata, hd_rdata, nx_wdata, nx_rdata;
  logic [BW-1:0] bk_wdata, bk_rdata;

  // unlink step decode
  logic          in_vld, accept, is_add, err, bl_head, empty_after;
  logic [IW-1:0] bl_idx;
  logic [CW-1:0] newc;

  assign accept      = start && !busy;
  assign in_vld      = (in_data.value != '0) && (32'(in_data.value) <= VALUES);
  assign is_add      = (op_r == fbmt_pkg::OP_ADD);
  assign bl_head     = bk_rdata[BW-1];
  assign bl_idx      = bk_rdata[IW-1:0];
  assign err         = !vld_r || (is_add ? (32'(cnt_rdata) >= MAX_COUNT)
                                         : (cnt_rdata == '0));
  assign newc        = is_add ? cnt_rdata + 1'b1 : cnt_rdata - 1'b1;
  // old bucket runs empty when v was its head and had no successor
  assign empty_after = bl_head && (nx_rdata == '0);
  assign clr_inc     = {1'b0, clr_idx_r} + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbmt_pkg::ST_CLEAR: begin
        if (clr_idx_r == CLW'(NCLR - 1)) begin
          state_nxt = fbmt_pkg::ST_IDLE;
        end
      end
      fbmt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = fbmt_pkg::ST_UNLINK;
        end
      end
      fbmt_pkg::ST_UNLINK: begin
        state_nxt = err ? fbmt_pkg::ST_IDLE : fbmt_pkg::ST_LINK;
      end
      fbmt_pkg::ST_LINK: state_nxt = fbmt_pkg::ST_FIX;
      fbmt_pkg::ST_FIX:  state_nxt = fbmt_pkg::ST_IDLE;
      default:           state_nxt = fbmt_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    op_nxt        = op_r;
    v_nxt         = v_r;
    vld_nxt       = vld_r;
    newc_nxt      = newc_r;
    highest_nxt   = highest_r;
    mode_nxt      = mode_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    hd_we     = 1'b0;
    hd_waddr  = '0;
    hd_wdata  = '0;
    nx_we     = 1'b0;
    nx_waddr  = '0;
    nx_wdata  = '0;
    bk_we     = 1'b0;
    bk_waddr  = '0;
    bk_wdata  = '0;

    // lookups for a new beat are issued in the accept cycle
    cnt_raddr = in_vld ? VW'(in_data.value) : '0;
    nx_raddr  = cnt_raddr;
    bk_raddr  = cnt_raddr;
    hd_raddr  = newc;

    unique case (state_r)
      fbmt_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_inc[CLW-1:0];
        cnt_we      = 32'(clr_idx_r) <= VALUES;
        cnt_waddr   = VW'(clr_idx_r);
        nx_we       = cnt_we;
        nx_waddr    = VW'(clr_idx_r);
        nx_wdata    = (32'(clr_idx_r) < VALUES) ? VW'(clr_inc) : '0;
        bk_we       = cnt_we;
        bk_waddr    = VW'(clr_idx_r);
        bk_wdata    = (clr_idx_r == CLW'(1)) ? {1'b1, IW'(0)}
                                             : {1'b0, IW'(clr_idx_r - 1'b1)};
        hd_we       = 32'(clr_idx_r) <= MAX_COUNT;
        hd_waddr    = CW'(clr_idx_r);
      end
      fbmt_pkg::ST_IDLE: begin
        if (start) begin
          op_nxt  = in_data.opcode;
          v_nxt   = VW'(in_data.value);
          vld_nxt = in_vld;
        end
      end
      fbmt_pkg::ST_UNLINK: begin
        if (err) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.mode_value = OVW'(mode_r);
          out_data_nxt.max_count  = OCW'(highest_r);
          out_data_nxt.error      = 1'b1;
        end else begin
          newc_nxt  = newc;
          cnt_we    = 1'b1;
          cnt_waddr = v_r;
          cnt_wdata = newc;
          // cut v out: whatever pointed at v now points at its successor
          if (bl_head) begin
            hd_we    = 32'(bl_idx) <= MAX_COUNT;
            hd_waddr = CW'(bl_idx);
            hd_wdata = nx_rdata;
          end else begin
            nx_we    = (bl_idx != '0) && (32'(bl_idx) <= VALUES);
            nx_waddr = VW'(bl_idx);
            nx_wdata = nx_rdata;
          end
          bk_we    = nx_rdata != '0;
          bk_waddr = nx_rdata;
          bk_wdata = bk_rdata;
          // v lands at the head of its new bucket, so the mode follows directly
          if (is_add) begin
            if (newc >= highest_r) begin
              highest_nxt = newc;
              mode_nxt    = v_r;
            end
          end else if (cnt_rdata == highest_r) begin
            if (empty_after) begin
              highest_nxt = newc;
              mode_nxt    = (newc != '0) ? v_r : '0;
            end else if (bl_head) begin
              mode_nxt = nx_rdata;
            end
          end
        end
      end
      fbmt_pkg::ST_LINK: begin
        bk_we    = hd_rdata != '0;
        bk_waddr = hd_rdata;
        bk_wdata = {1'b0, IW'(v_r)};
        nx_we    = 1'b1;
        nx_waddr = v_r;
        nx_wdata = hd_rdata;
        hd_we    = 1'b1;
        hd_waddr = newc_r;
        hd_wdata = v_r;
      end
      fbmt_pkg::ST_FIX: begin
        bk_we                   = 1'b1;
        bk_waddr                = v_r;
        bk_wdata                = {1'b1, IW'(newc_r)};
        out_valid_nxt           = 1'b1;
        out_data_nxt.mode_value = OVW'(mode_r);
        out_data_nxt.max_count  = OCW'(highest_r);
        out_data_nxt.error      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbmt_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      highest_r   <= '0;
      mode_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      highest_r   <= highest_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    v_r        <= v_nxt;
    vld_r      <= vld_nxt;
    newc_r     <= newc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != fbmt_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  fbmt_ram #(.DEPTH(VALUES + 1), .WIDTH(CW)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  fbmt_ram #(.DEPTH(MAX_COUNT + 1), .WIDTH(VW)) u_head (
    .clk   (clk),
    .we    (hd_we),
    .waddr (hd_waddr),
    .wdata (hd_wdata),
    .raddr (hd_raddr),
    .rdata (hd_rdata)
  );

  fbmt_ram #(.DEPTH(VALUES + 1), .WIDTH(VW)) u_next (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  fbmt_ram #(.DEPTH(VALUES + 1), .WIDTH(BW)) u_back (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  `FBMT_ASSERT_NEXT(a_accept_unlink, accept, state_r == fbmt_pkg::ST_UNLINK, "beat not sequenced")
  `FBMT_ASSERT_NOW(a_link_order, state_r == fbmt_pkg::ST_LINK, $past(state_r) == fbmt_pkg::ST_UNLINK, "link without unlink")
  `FBMT_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r, "result strobe held twice")
  `FBMT_ASSERT_NOW(a_empty_mode, highest_r == '0, mode_r == '0, "mode set with nothing held")

endmodule

`default_nettype wire

FILE: rtl/fbmt_ram.sv
// Simple dual-port synchronous RAM: one write, one read, registered read data.
// No dependencies.
`default_nettype none

module fbmt_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
